/* rtl/assert_macros.svh */
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

/* rtl/rsor_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsor_pkg
// shared types and constants of the residual outlier filter
// ----------------------------------------------------------------------------
package rsor_pkg;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_POINTS = 524288;
    localparam int CNT_W      = 20;
    localparam logic [31:0] CAP_Q = 32'(100 << FRAC_BITS);
    localparam logic [CNT_W-1:0] REJ_MAX = '1;

    typedef enum logic [1:0] {
        OP_ACC = 2'd0, OP_FIN = 2'd1, OP_CLS = 2'd2, OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_CX0 = 3'd0, REG_CXX = 3'd1, REG_CXY = 3'd2, REG_CY0 = 3'd3,
        REG_CYX = 3'd4, REG_CYY = 3'd5, REG_SCX = 3'd6, REG_SCY = 3'd7
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_SCALE, S_SQ, S_ACC, S_CLS,
        S_DIV, S_MSQ, S_SQRT, S_FIN, S_OUT
    } t_state;

    typedef struct packed {
        logic load;      // capture input item
        logic mul1;      // slope products, both axes
        logic mul2;      // pixel residual
        logic scale;     // scale to m/yr
        logic sq;        // squares
        logic acc;       // add to sums
        logic cls;       // classify
        logic div_start; // start dividers
        logic msq;       // mean and mean square
        logic sqrt_start;
        logic fin;       // finish: thresholds and clear
        logic fin_empty;
    } t_cmd;

    typedef struct packed {
        logic count_full;
        logic count_zero;
        logic div_done;
        logic sqrt_done;
    } t_stat;
endpackage

/* rtl/rsor_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsor_div
// restoring divider, 64 by 20 bits, one quotient bit a cycle
// ----------------------------------------------------------------------------
module rsor_div import rsor_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [63:0]      i_num,
    input  logic [CNT_W-1:0] i_den,
    output logic [63:0]      o_quo,
    output logic             o_done
);
    logic [63:0]      r_q, n_q;
    logic [CNT_W:0]   r_rem, n_rem;
    logic [CNT_W-1:0] r_den;
    logic [6:0]       r_cnt;
    logic             r_busy;
    logic [CNT_W:0]   w_t;

    always_comb begin
        w_t   = {r_rem[CNT_W-1:0], r_q[63]};
        n_q   = {r_q[62:0], 1'b0};
        n_rem = w_t;
        if (w_t >= {1'b0, r_den}) begin
            n_rem = w_t - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd0;
            r_q    <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
            r_cnt <= r_cnt + 7'd1;
            if (r_cnt == 7'd63) r_busy <= 1'b0;
        end
    end

    assign o_quo  = r_q;
    assign o_done = !r_busy && !i_start;
endmodule

/* rtl/rsor_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsor_sqrt
// integer square root of a 64-bit value, one result bit a cycle
// ----------------------------------------------------------------------------
module rsor_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic [31:0] o_root,
    output logic        o_done
);
    logic [63:0] r_v, r_r, r_bit, n_v, n_r;
    logic        r_busy;

    always_comb begin
        n_v = r_v;
        n_r = r_r >> 1;
        if (r_v >= r_r + r_bit) begin
            n_v = r_v - (r_r + r_bit);
            n_r = (r_r >> 1) + r_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_v    <= i_val;
            r_r    <= '0;
            r_bit  <= 64'd1 << 62;
        end else if (r_busy) begin
            r_v   <= n_v;
            r_r   <= n_r;
            r_bit <= r_bit >> 2;
            if (r_bit == 64'd1) r_busy <= 1'b0;
        end
    end

    assign o_root = r_r[31:0];
    assign o_done = !r_busy && !i_start;
endmodule

/* rtl/rsor_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsor_datapath
// residual arithmetic, running sums, statistics and thresholds
// ----------------------------------------------------------------------------
module rsor_datapath import rsor_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [31:0]      i_cfg_data,
    input  logic [31:0]      i_pos_x,
    input  logic [31:0]      i_pos_y,
    input  logic [31:0]      i_off_x,
    input  logic [31:0]      i_off_y,
    output logic [31:0]      o_mean_x,
    output logic [31:0]      o_mean_y,
    output logic [30:0]      o_sigma_x,
    output logic [30:0]      o_sigma_y,
    output logic [CNT_W-1:0] o_used_count,
    output logic             o_no_points,
    output logic             o_keep,
    output logic [CNT_W-1:0] o_reject_count
);
    logic signed [31:0] r_cx0, r_cxx, r_cxy, r_cy0, r_cyx, r_cyy;
    logic        [31:0] r_scx, r_scy;
    logic signed [31:0] r_px, r_py, r_ox, r_oy;
    logic signed [63:0] r_pxa, r_pya, r_pxb, r_pyb;
    logic signed [31:0] r_rpx, r_rpy, r_rx, r_ry;
    logic        [63:0] r_sqx, r_sqy;
    logic signed [63:0] r_srx, r_sry;
    logic        [63:0] r_ssx, r_ssy;
    logic [CNT_W-1:0]   r_cnt, r_rej;
    logic [31:0]        r_thx, r_thy;
    logic signed [31:0] r_mx, r_my;
    logic        [63:0] r_varx, r_vary;
    logic        [63:0] r_vx2, r_vy2;

    function automatic logic signed [31:0] f_sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] f_sadd(input logic signed [63:0] a,
                                                 input logic signed [31:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic [63:0] f_uadd(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic f_abs_le(input logic signed [31:0] r,
                                      input logic [31:0] t);
        logic [32:0] a;
        a = r[31] ? 33'(-{r[31], r}) : 33'({1'b0, r});
        return (a <= {1'b0, t});
    endfunction

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx0 <= '0; r_cxx <= '0; r_cxy <= '0;
            r_cy0 <= '0; r_cyx <= '0; r_cyy <= '0;
            r_scx <= 32'(1 << FRAC_BITS);
            r_scy <= 32'(1 << FRAC_BITS);
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_idx))
                REG_CX0: r_cx0 <= i_cfg_data;
                REG_CXX: r_cxx <= i_cfg_data;
                REG_CXY: r_cxy <= i_cfg_data;
                REG_CY0: r_cy0 <= i_cfg_data;
                REG_CYX: r_cyx <= i_cfg_data;
                REG_CYY: r_cyy <= i_cfg_data;
                REG_SCX: r_scx <= i_cfg_data;
                REG_SCY: r_scy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // residual pipeline: two multipliers per axis for the slope products, one per axis to scale and square
    logic signed [65:0] w_rpx, w_rpy;
    logic signed [64:0] w_scx, w_scy;
    assign w_rpx = 66'(r_ox) - 66'(r_cx0) - 66'(r_pxa >>> FRAC_BITS)
                 - 66'(r_pya >>> FRAC_BITS);
    assign w_rpy = 66'(r_oy) - 66'(r_cy0) - 66'(r_pxb >>> FRAC_BITS)
                 - 66'(r_pyb >>> FRAC_BITS);
    assign w_scx = 65'(r_rpx) * $signed({33'd0, r_scx});
    assign w_scy = 65'(r_rpy) * $signed({33'd0, r_scy});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pos_x; r_py <= i_pos_y; r_ox <= i_off_x; r_oy <= i_off_y;
        end
        if (i_cmd.mul1) begin
            r_pxa <= r_cxx * r_px; r_pya <= r_cxy * r_py;
            r_pxb <= r_cyx * r_px; r_pyb <= r_cyy * r_py;
        end
        if (i_cmd.mul2) begin
            r_rpx <= f_sat32(w_rpx);
            r_rpy <= f_sat32(w_rpy);
        end
        if (i_cmd.scale) begin
            r_rx <= f_sat32(66'(w_scx >>> FRAC_BITS));
            r_ry <= f_sat32(66'(w_scy >>> FRAC_BITS));
        end
        if (i_cmd.sq) begin
            r_sqx <= 64'(r_rx * r_rx) >> FRAC_BITS;
            r_sqy <= 64'(r_ry * r_ry) >> FRAC_BITS;
        end
    end

    // dividers and roots
    logic [63:0] w_qrx, w_qry, w_qsx, w_qsy, w_nrx, w_nry;
    logic        w_d0, w_d1, w_d2, w_d3, w_s0, w_s1;
    logic [31:0] w_rtx, w_rty;
    logic [63:0] w_absx, w_absy;
    assign w_absx = r_srx[63] ? 64'(-r_srx) : 64'(r_srx);
    assign w_absy = r_sry[63] ? 64'(-r_sry) : 64'(r_sry);
    assign w_nrx  = r_srx[63] ? 64'(-w_qrx) : w_qrx;
    assign w_nry  = r_sry[63] ? 64'(-w_qry) : w_qry;

    rsor_div u_div_rx (.i_clk, .i_rst_n, .i_start(i_cmd.div_start), .i_num(w_absx),
                       .i_den(r_cnt), .o_quo(w_qrx), .o_done(w_d0));
    rsor_div u_div_ry (.i_clk, .i_rst_n, .i_start(i_cmd.div_start), .i_num(w_absy),
                       .i_den(r_cnt), .o_quo(w_qry), .o_done(w_d1));
    rsor_div u_div_sx (.i_clk, .i_rst_n, .i_start(i_cmd.div_start), .i_num(r_ssx),
                       .i_den(r_cnt), .o_quo(w_qsx), .o_done(w_d2));
    rsor_div u_div_sy (.i_clk, .i_rst_n, .i_start(i_cmd.div_start), .i_num(r_ssy),
                       .i_den(r_cnt), .o_quo(w_qsy), .o_done(w_d3));

    logic [63:0] w_vinx, w_viny;
    function automatic logic [63:0] f_vin(input logic [63:0] v);
        logic [63:0] lim;
        lim = 64'('1) >> FRAC_BITS;
        return ((v > lim) ? lim : v) << FRAC_BITS;
    endfunction
    assign w_vinx = f_vin(r_vx2);
    assign w_viny = f_vin(r_vy2);

    rsor_sqrt u_sqrt_x (.i_clk, .i_rst_n, .i_start(i_cmd.sqrt_start), .i_val(w_vinx),
                        .o_root(w_rtx), .o_done(w_s0));
    rsor_sqrt u_sqrt_y (.i_clk, .i_rst_n, .i_start(i_cmd.sqrt_start), .i_val(w_viny),
                        .o_root(w_rty), .o_done(w_s1));

    logic [30:0] w_sgx, w_sgy;
    assign w_sgx = w_rtx[31] ? 31'h7fffffff : w_rtx[30:0];
    assign w_sgy = w_rty[31] ? 31'h7fffffff : w_rty[30:0];

    function automatic logic [31:0] f_clip(input logic [30:0] s);
        return ({s, 1'b0} > CAP_Q) ? CAP_Q : {s, 1'b0};
    endfunction

    logic w_kx, w_ky, w_keep;
    assign w_kx   = f_abs_le(r_rx, r_thx);
    assign w_ky   = f_abs_le(r_ry, r_thy);
    assign w_keep = w_kx && w_ky;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srx <= '0; r_sry <= '0; r_ssx <= '0; r_ssy <= '0;
            r_cnt <= '0; r_rej <= '0; r_thx <= CAP_Q; r_thy <= CAP_Q;
        end else begin
            if (i_cmd.acc) begin
                r_srx <= f_sadd(r_srx, r_rx);
                r_sry <= f_sadd(r_sry, r_ry);
                r_ssx <= f_uadd(r_ssx, r_sqx);
                r_ssy <= f_uadd(r_ssy, r_sqy);
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.cls) begin
                o_keep <= w_keep;
                if (!w_keep && r_rej != REJ_MAX) begin
                    r_rej          <= r_rej + 1'b1;
                    o_reject_count <= r_rej + 1'b1;
                end else begin
                    o_reject_count <= r_rej;
                end
                o_mean_x <= '0; o_mean_y <= '0; o_sigma_x <= '0; o_sigma_y <= '0;
                o_used_count <= '0; o_no_points <= 1'b0;
            end
            if (i_cmd.fin) begin
                o_used_count <= r_cnt;
                o_keep <= 1'b0; o_reject_count <= '0;
                if (i_cmd.fin_empty) begin
                    o_no_points <= 1'b1;
                    o_mean_x <= '0; o_mean_y <= '0; o_sigma_x <= '0; o_sigma_y <= '0;
                    r_thx <= CAP_Q; r_thy <= CAP_Q;
                end else begin
                    o_no_points <= 1'b0;
                    o_mean_x <= r_mx; o_mean_y <= r_my;
                    o_sigma_x <= w_sgx; o_sigma_y <= w_sgy;
                    r_thx <= f_clip(w_sgx); r_thy <= f_clip(w_sgy);
                end
                r_srx <= '0; r_sry <= '0; r_ssx <= '0; r_ssy <= '0;
                r_cnt <= '0; r_rej <= '0;
            end
        end
    end

    // mean and mean square
    always_ff @(posedge i_clk) begin
        if (i_cmd.msq) begin
            r_mx  <= f_sat32(66'($signed(w_nrx)));
            r_my  <= f_sat32(66'($signed(w_nry)));
            r_varx <= w_qsx;
            r_vary <= w_qsy;
        end
    end

    // squared mean taken in the cycle after msq: squares from registered means
    logic [63:0] w_m2x, w_m2y;
    assign w_m2x = 64'(r_mx * r_mx) >> FRAC_BITS;
    assign w_m2y = 64'(r_my * r_my) >> FRAC_BITS;
    always_ff @(posedge i_clk) begin
        if (i_cmd.sq && !i_cmd.load) begin
            r_vx2 <= (r_varx > w_m2x) ? r_varx - w_m2x : '0;
            r_vy2 <= (r_vary > w_m2y) ? r_vary - w_m2y : '0;
        end
    end

    assign o_stat.count_full = (r_cnt >= CNT_W'(MAX_POINTS));
    assign o_stat.count_zero = (r_cnt == '0);
    assign o_stat.div_done   = w_d0 & w_d1 & w_d2 & w_d3;
    assign o_stat.sqrt_done  = w_s0 & w_s1;
endmodule

/* rtl/rsor_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsor_ctrl
// sequencer for accumulate, classify and finish items
// ----------------------------------------------------------------------------
module rsor_ctrl import rsor_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_op,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       o_valid,
    input  logic       i_stall
);
    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_ovalid, n_ovalid;
    logic   w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_NONE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign w_acc   = i_valid && !o_stall;
    assign o_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_ovalid = r_ovalid && i_stall;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.load = 1'b1;
                    n_op = t_op'(i_op);
                    case (t_op'(i_op))
                        OP_ACC:  n_state = i_stat.count_full ? S_IDLE : S_MUL1;
                        OP_CLS:  n_state = S_MUL1;
                        OP_FIN:  n_state = S_DIV;
                        default: n_state = S_IDLE;
                    endcase
                    if (t_op'(i_op) == OP_FIN && i_stat.count_zero) n_state = S_FIN;
                end
            end
            S_MUL1:  begin o_cmd.mul1 = 1'b1;  n_state = S_MUL2;  end
            S_MUL2:  begin o_cmd.mul2 = 1'b1;  n_state = S_SCALE; end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state = (r_op == OP_ACC) ? S_SQ : S_CLS;
            end
            S_SQ:    begin o_cmd.sq = 1'b1;    n_state = S_ACC;   end
            S_ACC:   begin o_cmd.acc = 1'b1;   n_state = S_IDLE;  end
            S_CLS: begin
                if (!r_ovalid || !i_stall) begin
                    o_cmd.cls = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = S_MSQ;
            end
            S_MSQ: begin
                if (i_stat.div_done) begin
                    o_cmd.msq = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.sq = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_start = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_stat.sqrt_done && (!r_ovalid || !i_stall)) begin
                    o_cmd.fin = 1'b1;
                    o_cmd.fin_empty = i_stat.count_zero;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

/* rtl/residual_stats_outlier_reject.sv */
`timescale 1ns / 1ps
// accumulate: load, slope products, pixel residual, scale, square, add to sums
// classify: same chain up to scale, then classify once the output side can take it
// finish: dividers, mean and mean square, variance, root, thresholds and result,
// paced by the 64-step divider and 32-step root; with no points straight to the result
// one item at a time; result register frees the output side
// synchronous active-low reset: sums cleared, thresholds 100.0, scales 1.0
// ----------------------------------------------------------------------------
// residual_stats_outlier_reject
// sigma-clipping residual filter for tie points
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module residual_stats_outlier_reject import rsor_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_op,
    input  logic [31:0]      i_pos_x,
    input  logic [31:0]      i_pos_y,
    input  logic [31:0]      i_off_x,
    input  logic [31:0]      i_off_y,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [31:0]      o_mean_x,
    output logic [31:0]      o_mean_y,
    output logic [30:0]      o_sigma_x,
    output logic [30:0]      o_sigma_y,
    output logic [CNT_W-1:0] o_used_count,
    output logic             o_no_points,
    output logic             o_keep,
    output logic [CNT_W-1:0] o_reject_count
);
    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: one transfer in, at most one result transfer out
    rsor_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_op,
        .i_stat(w_stat), .o_cmd(w_cmd), .o_valid, .i_stall
    );

    // arithmetic and state
    rsor_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_stat(w_stat),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_pos_x, .i_pos_y, .i_off_x, .i_off_y,
        .o_mean_x, .o_mean_y, .o_sigma_x, .o_sigma_y, .o_used_count,
        .o_no_points, .o_keep, .o_reject_count
    );

    // a result is never overwritten while it waits
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, o_valid && i_stall && (w_cmd.cls || w_cmd.fin))
    // only one kind of result at a time
    `ASSERT_NEVER(a_one_result, i_clk, i_rst_n, w_cmd.cls && w_cmd.fin)
    // sum update never coincides with accepting a new item
    `ASSERT_NEVER(a_acc_busy, i_clk, i_rst_n, w_cmd.acc && !o_stall)
endmodule
